@@ rtl/mrbg_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mrbg_pkg
// Shared constants and types of the maximal free rectangle finder.
// ----------------------------------------------------------------------------
package mrbg_pkg;

   // grid character that marks a free cell
   localparam int unsigned CHAR_W = 8;
   localparam logic [CHAR_W-1:0] FREE_CHAR = 8'h46;

   // width of the column count register
   localparam int unsigned CFG_W = 11;

   // result width, area saturates at all ones
   localparam int unsigned AREA_W = 20;
   localparam logic [AREA_W-1:0] AREA_MAX = '1;

   // stack command from the row controller
   typedef struct packed {
      logic clear;
      logic push;
      logic pop;
   } mrbg_stack_cmd_type;

endpackage
`default_nettype wire

@@ rtl/mrbg_col_mem.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mrbg_col_mem
// Column height memory: one write and one registered read port.
// ----------------------------------------------------------------------------
module mrbg_col_mem #(
   parameter int unsigned MAX_COLUMNS  = 1024,
   parameter int unsigned HEIGHT_LIMIT = 1023
) (
   input  wire logic                                clock,
   input  wire logic                                wr_en,
   input  wire logic [$clog2(MAX_COLUMNS)-1:0]      wr_addr,
   input  wire logic [$clog2(HEIGHT_LIMIT+1)-1:0]   wr_data,
   input  wire logic                                rd_en,
   input  wire logic [$clog2(MAX_COLUMNS)-1:0]      rd_addr,
   output logic      [$clog2(HEIGHT_LIMIT+1)-1:0]   rd_data
);

   localparam int unsigned H_W = $clog2(HEIGHT_LIMIT + 1);

   logic [H_W-1:0] mem [MAX_COLUMNS];
   logic [H_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ rtl/mrbg_stack.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mrbg_stack
// Monotonic height/span stack: top entry held in registers, the entries
// below it in a synchronous memory refilled one pop per cycle.
// ----------------------------------------------------------------------------
module mrbg_stack
   import mrbg_pkg::*;
#(
   parameter int unsigned MAX_COLUMNS  = 1024,
   parameter int unsigned HEIGHT_LIMIT = 1023
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire mrbg_stack_cmd_type                   cmd,
   input  wire logic [$clog2(HEIGHT_LIMIT+1)-1:0]    push_height,
   input  wire logic [$clog2(MAX_COLUMNS+1)-1:0]     push_span,
   output logic      [$clog2(HEIGHT_LIMIT+1)-1:0]    top_height,
   output logic      [$clog2(MAX_COLUMNS+1)-1:0]     top_span,
   output logic                                      empty
);

   localparam int unsigned COL_W = $clog2(MAX_COLUMNS);
   localparam int unsigned CNT_W = $clog2(MAX_COLUMNS + 1);
   localparam int unsigned H_W   = $clog2(HEIGHT_LIMIT + 1);

   logic [H_W-1:0]   mem_h [MAX_COLUMNS];
   logic [CNT_W-1:0] mem_s [MAX_COLUMNS];

   logic [CNT_W-1:0] depth_ff, depth_in;
   logic             load_tos_ff, load_tos_in;
   logic [H_W-1:0]   tos_h_ff, tos_h_in, rd_h_ff;
   logic [CNT_W-1:0] tos_s_ff, tos_s_in, rd_s_ff;
   logic             wr_en, rd_en;
   logic [COL_W-1:0] wr_addr, rd_addr;

   // top comes from the memory read right after a pop
   assign top_height = load_tos_ff ? rd_h_ff : tos_h_ff;
   assign top_span   = load_tos_ff ? rd_s_ff : tos_s_ff;
   assign empty      = (depth_ff == '0);

   // push, pop and clear
   always_comb begin
      depth_in    = depth_ff;
      tos_h_in    = top_height;
      tos_s_in    = top_span;
      load_tos_in = 1'b0;
      wr_en       = 1'b0;
      rd_en       = 1'b0;
      wr_addr     = COL_W'(depth_ff - 1'b1);
      rd_addr     = COL_W'(depth_ff - CNT_W'(2));
      if (cmd.clear) begin
         depth_in = '0;
      end else if (cmd.push && (depth_ff < CNT_W'(MAX_COLUMNS))) begin
         // old top moves down into the memory
         wr_en    = (depth_ff != '0);
         tos_h_in = push_height;
         tos_s_in = push_span;
         depth_in = depth_ff + 1'b1;
      end else if (cmd.pop && (depth_ff != '0)) begin
         depth_in = depth_ff - 1'b1;
         if (depth_ff > CNT_W'(1)) begin
            rd_en       = 1'b1;
            load_tos_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff    <= '0;
         load_tos_ff <= 1'b0;
      end else begin
         depth_ff    <= depth_in;
         load_tos_ff <= load_tos_in;
      end
   end

   // top of stack
   always_ff @(posedge clock) begin
      tos_h_ff <= tos_h_in;
      tos_s_ff <= tos_s_in;
   end

   // entry memory, write then registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_h[wr_addr] <= top_height;
         mem_s[wr_addr] <= top_span;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_h_ff <= mem_h[rd_addr];
         rd_s_ff <= mem_s[rd_addr];
      end
   end

endmodule
`default_nettype wire

@@ rtl/mrbg_area.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mrbg_area
// Area of each popped rectangle, saturated, and the running best area.
// ----------------------------------------------------------------------------
module mrbg_area
   import mrbg_pkg::*;
#(
   parameter int unsigned MAX_COLUMNS  = 1024,
   parameter int unsigned HEIGHT_LIMIT = 1023
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 clear,
   input  wire logic                                 cand_valid,
   input  wire logic [$clog2(HEIGHT_LIMIT+1)-1:0]    cand_height,
   input  wire logic [$clog2(MAX_COLUMNS+1)-1:0]     cand_span,
   output logic                                      pending,
   output logic      [AREA_W-1:0]                    best_area
);

   localparam int unsigned CNT_W  = $clog2(MAX_COLUMNS + 1);
   localparam int unsigned H_W    = $clog2(HEIGHT_LIMIT + 1);
   localparam int unsigned PROD_W = H_W + CNT_W;
   localparam int unsigned WIDE_W = (PROD_W > AREA_W) ? PROD_W : AREA_W;

   logic              cand_valid_ff;
   logic [H_W-1:0]    cand_h_ff;
   logic [CNT_W-1:0]  cand_s_ff;
   logic [PROD_W-1:0] product;
   logic [WIDE_W-1:0] product_wide;
   logic [AREA_W-1:0] area_sat;
   logic [AREA_W-1:0] best_ff, best_in;

   // candidate register ahead of the multiplier
   always_ff @(posedge clock) begin
      if (reset) begin
         cand_valid_ff <= 1'b0;
      end else begin
         cand_valid_ff <= cand_valid;
      end
   end

   always_ff @(posedge clock) begin
      cand_h_ff <= cand_height;
      cand_s_ff <= cand_span;
   end

   // multiply and saturate
   assign product      = PROD_W'(cand_h_ff) * PROD_W'(cand_s_ff);
   assign product_wide = WIDE_W'(product);
   assign area_sat     = (product_wide > WIDE_W'(AREA_MAX)) ? AREA_MAX
                                                            : AREA_W'(product_wide);

   // running maximum, clear wins
   always_comb begin
      best_in = best_ff;
      if (clear) begin
         best_in = '0;
      end else if (cand_valid_ff && (area_sat > best_ff)) begin
         best_in = area_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff <= '0;
      end else begin
         best_ff <= best_in;
      end
   end

   assign pending   = cand_valid_ff;
   assign best_area = best_ff;

endmodule
`default_nettype wire

@@ rtl/max_rectangle_binary_grid.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// max_rectangle_binary_grid
// Largest all-free rectangle of a character grid streamed in row-major order.
// ----------------------------------------------------------------------------
// Cells enter one request at a time; 'F' is free, anything else blocked. A
// request passes through accept, then column height lookup and update, then
// one pop step per stack entry it pops and one closing push step when it pops
// at all. The last cell of a row then pops every entry left on the stack and
// takes one final step. The end-of-matrix cell then enters a drain step that
// loads max_area into the output register, which offers it in the following
// cycle; the drain waits longer while an earlier result is still held by
// rsp_stall. The stack memory yields one entry per cycle.
// Column heights are never swept: a fill count marks which columns were
// written since the start flag, so the block is ready right after reset.
// The column count is written through the csr channel while no request is in
// flight; zero acts as one and values above MAX_COLUMNS as MAX_COLUMNS.
module max_rectangle_binary_grid
   import mrbg_pkg::*;
#(
   parameter int unsigned MAX_COLUMNS  = 1024,
   parameter int unsigned HEIGHT_LIMIT = 1023
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // request channel
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [CHAR_W-1:0]  req_cell_char,
   input  wire logic               req_start_of_matrix,
   input  wire logic               req_end_of_matrix,
   // result channel
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic      [AREA_W-1:0]  rsp_max_area,
   // column count register
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [CFG_W-1:0]   csr_num_columns
);

   localparam int unsigned COL_W = $clog2(MAX_COLUMNS);
   localparam int unsigned CNT_W = $clog2(MAX_COLUMNS + 1);
   localparam int unsigned H_W   = $clog2(HEIGHT_LIMIT + 1);
   localparam int unsigned CMP_W = (CFG_W > CNT_W) ? CFG_W : CNT_W;

   localparam int unsigned ST_W    = 3;
   localparam logic [ST_W-1:0] S_IDLE  = 3'd0;
   localparam logic [ST_W-1:0] S_LOOK  = 3'd1;
   localparam logic [ST_W-1:0] S_POP   = 3'd2;
   localparam logic [ST_W-1:0] S_FLUSH = 3'd3;
   localparam logic [ST_W-1:0] S_DRAIN = 3'd4;

   logic [ST_W-1:0]   state_ff, state_in;
   logic [CNT_W-1:0]  cols_ff, cols_in;
   logic [COL_W-1:0]  column_index_ff, column_index_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic              col_valid_ff, col_valid_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [H_W-1:0]    prev_ff, prev_in;
   logic              row_started_ff, row_started_in;
   logic [H_W-1:0]    h_ff, h_in;
   logic              free_ff, free_in;
   logic              end_ff, end_in;
   logic [CNT_W-1:0]  sum_ff, sum_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [AREA_W-1:0] rsp_area_ff, rsp_area_in;

   logic               col_rd_en, col_wr_en;
   logic [COL_W-1:0]   col_rd_addr;
   logic [H_W-1:0]     col_rd_data;
   mrbg_stack_cmd_type stack_cmd;
   logic [H_W-1:0]     push_h, top_h;
   logic [CNT_W-1:0]   push_s, top_s;
   logic               stack_empty;
   logic               area_clear, cand_valid, area_pending;
   logic [CNT_W-1:0]   cand_s;
   logic [AREA_W-1:0]  best_area;

   logic [CMP_W-1:0]   csr_wide;
   logic               accept;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = (state_ff == S_IDLE) && !req_valid;
   assign csr_wide  = CMP_W'(csr_num_columns);

   // column count, clamped on write
   always_comb begin
      cols_in = cols_ff;
      if (csr_valid && csr_ready) begin
         if (csr_wide == '0) begin
            cols_in = CNT_W'(1);
         end else if (csr_wide > CMP_W'(MAX_COLUMNS)) begin
            cols_in = CNT_W'(MAX_COLUMNS);
         end else begin
            cols_in = CNT_W'(csr_wide);
         end
      end
   end

   // row controller
   always_comb begin
      logic [COL_W-1:0] col_sel;
      logic [H_W-1:0]   h_rd;
      logic [H_W-1:0]   h_new;
      logic             row_last;
      logic             do_push;

      state_in        = state_ff;
      column_index_in = column_index_ff;
      col_in          = col_ff;
      col_valid_in    = col_valid_ff;
      fill_in         = fill_ff;
      prev_in         = prev_ff;
      row_started_in  = row_started_ff;
      h_in            = h_ff;
      free_in         = free_ff;
      end_in          = end_ff;
      sum_in          = sum_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_area_in     = rsp_area_ff;

      col_rd_en   = 1'b0;
      col_wr_en   = 1'b0;
      stack_cmd   = '0;
      push_h      = h_ff;
      push_s      = CNT_W'(1);
      area_clear  = 1'b0;
      cand_valid  = 1'b0;
      cand_s      = sum_ff + top_s;
      do_push     = 1'b0;

      // column of the arriving cell
      col_sel = req_start_of_matrix ? '0 : column_index_ff;
      if (CNT_W'(col_sel) >= cols_ff) begin
         col_sel = '0;
      end
      col_rd_addr = col_sel;

      // new run height of the current column
      h_rd  = col_valid_ff ? col_rd_data : '0;
      h_new = '0;
      if (free_ff) begin
         h_new = (h_rd < H_W'(HEIGHT_LIMIT)) ? H_W'(h_rd + 1'b1) : H_W'(HEIGHT_LIMIT);
      end
      row_last = ((CNT_W'(col_ff) + 1'b1) >= cols_ff) || end_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               col_rd_en = 1'b1;
               col_in    = col_sel;
               free_in   = (req_cell_char == FREE_CHAR);
               end_in    = req_end_of_matrix;
               if (req_start_of_matrix) begin
                  stack_cmd.clear = 1'b1;
                  area_clear      = 1'b1;
                  fill_in         = '0;
                  row_started_in  = 1'b0;
                  prev_in         = '0;
                  col_valid_in    = 1'b0;
               end else begin
                  col_valid_in = (CNT_W'(col_sel) < fill_ff);
               end
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            col_wr_en      = 1'b1;
            h_in           = h_new;
            prev_in        = h_new;
            row_started_in = 1'b1;
            if (CNT_W'(col_ff) == fill_ff) begin
               fill_in = CNT_W'(col_ff) + 1'b1;
            end
            if (!row_started_ff || (h_new >= prev_ff)) begin
               push_h  = h_new;
               do_push = 1'b1;
            end else begin
               sum_in   = '0;
               state_in = S_POP;
            end
         end
         S_POP: begin
            if (!stack_empty && (top_h > h_ff)) begin
               stack_cmd.pop = 1'b1;
               cand_valid    = 1'b1;
               sum_in        = cand_s;
            end else begin
               push_s  = sum_ff + 1'b1;
               do_push = 1'b1;
            end
         end
         S_FLUSH: begin
            if (!stack_empty) begin
               stack_cmd.pop = 1'b1;
               cand_valid    = 1'b1;
               sum_in        = cand_s;
            end else begin
               column_index_in = '0;
               prev_in         = '0;
               row_started_in  = 1'b0;
               state_in        = end_ff ? S_DRAIN : S_IDLE;
            end
         end
         S_DRAIN: begin
            // wait for the last area, then for a free output register
            if (!area_pending && !rsp_valid_in) begin
               rsp_valid_in = 1'b1;
               rsp_area_in  = best_area;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // push closes the cell: flush the row or step to the next column
      if (do_push) begin
         stack_cmd.push = 1'b1;
         if (row_last) begin
            sum_in   = '0;
            state_in = S_FLUSH;
         end else begin
            column_index_in = col_ff + 1'b1;
            state_in        = S_IDLE;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         cols_ff         <= CNT_W'(MAX_COLUMNS);
         column_index_ff <= '0;
         fill_ff         <= '0;
         prev_ff         <= '0;
         row_started_ff  <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         cols_ff         <= cols_in;
         column_index_ff <= column_index_in;
         fill_ff         <= fill_in;
         prev_ff         <= prev_in;
         row_started_ff  <= row_started_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // request payload and working registers
   always_ff @(posedge clock) begin
      col_ff       <= col_in;
      col_valid_ff <= col_valid_in;
      h_ff         <= h_in;
      free_ff      <= free_in;
      end_ff       <= end_in;
      sum_ff       <= sum_in;
      rsp_area_ff  <= rsp_area_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_max_area = rsp_area_ff;

   // column heights
   mrbg_col_mem #(
      .MAX_COLUMNS  (MAX_COLUMNS),
      .HEIGHT_LIMIT (HEIGHT_LIMIT)
   ) u_col_mem (
      .clock   (clock),
      .wr_en   (col_wr_en),
      .wr_addr (col_ff),
      .wr_data (h_in),
      .rd_en   (col_rd_en),
      .rd_addr (col_rd_addr),
      .rd_data (col_rd_data)
   );

   // height/span stack
   mrbg_stack #(
      .MAX_COLUMNS  (MAX_COLUMNS),
      .HEIGHT_LIMIT (HEIGHT_LIMIT)
   ) u_stack (
      .clock       (clock),
      .reset       (reset),
      .cmd         (stack_cmd),
      .push_height (push_h),
      .push_span   (push_s),
      .top_height  (top_h),
      .top_span    (top_s),
      .empty       (stack_empty)
   );

   // rectangle areas and best area
   mrbg_area #(
      .MAX_COLUMNS  (MAX_COLUMNS),
      .HEIGHT_LIMIT (HEIGHT_LIMIT)
   ) u_area (
      .clock       (clock),
      .reset       (reset),
      .clear       (area_clear),
      .cand_valid  (cand_valid),
      .cand_height (top_h),
      .cand_span   (cand_s),
      .pending     (area_pending),
      .best_area   (best_area)
   );

`ifndef SYNTH
   // a result appears only out of the drain step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == S_DRAIN))
      else $error("result raised outside drain");

   // the looked-up column lies inside the row
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOOK) |-> (CNT_W'(col_ff) < cols_ff))
      else $error("column index beyond row length");

   // written columns form a prefix with the current column inside it or just past its end
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOOK) |-> (CNT_W'(col_ff) <= fill_ff))
      else $error("column outside written prefix");

   // no area still in flight when the result is loaded
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_DRAIN) && (state_in == S_IDLE)) |-> !area_pending)
      else $error("result loaded before last area");
`endif

endmodule
`default_nettype wire

@@ tb/max_rectangle_binary_grid_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_rectangle_binary_grid_checker
// Watches the request, result and csr channels of the free rectangle finder,
// keeps its own column heights and height/span stack, and compares every
// max_area it sees against the oldest predicted area.
// ----------------------------------------------------------------------------
module max_rectangle_binary_grid_checker
   import mrbg_pkg::*;
#(
   parameter int unsigned MAX_COLUMNS  = 1024,
   parameter int unsigned HEIGHT_LIMIT = 1023
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_stall,
   input  wire logic [CHAR_W-1:0] req_cell_char,
   input  wire logic              req_start_of_matrix,
   input  wire logic              req_end_of_matrix,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_stall,
   input  wire logic [AREA_W-1:0] rsp_max_area,
   input  wire logic              csr_valid,
   input  wire logic              csr_ready,
   input  wire logic [CFG_W-1:0]  csr_num_columns,
   output int                     mismatch_count,
   output int                     results_pending
);

   localparam int unsigned H_W    = $clog2(HEIGHT_LIMIT + 1);
   localparam int unsigned SPAN_W = $clog2(MAX_COLUMNS + 1);

   // grid state as the block should hold it
   logic [H_W-1:0]    run_height [MAX_COLUMNS];
   logic [H_W-1:0]    stack_h [MAX_COLUMNS];
   logic [SPAN_W-1:0] stack_w [MAX_COLUMNS];
   int unsigned       stack_top;
   int unsigned       next_col;
   int unsigned       last_height;
   bit                row_open;
   logic [AREA_W-1:0] best_area;
   logic [CFG_W-1:0]  num_columns;

   // areas still owed by the block, oldest first
   logic [AREA_W-1:0] expected_areas [$];

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   function automatic void record_area(longint unsigned h, longint unsigned span);
      longint unsigned a;
      a = h * span;
      if (a > AREA_MAX) a = AREA_MAX;
      if (a > best_area) best_area = a[AREA_W-1:0];
   endfunction

   // pop entries taller than floor_h, a negative floor empties the stack
   function automatic int unsigned pop_taller(int floor_h);
      int unsigned span_sum;
      span_sum = 0;
      while (stack_top > 0 && int'(stack_h[stack_top-1]) > floor_h) begin
         stack_top--;
         span_sum += stack_w[stack_top];
         record_area(stack_h[stack_top], span_sum);
      end
      return span_sum;
   endfunction

   function automatic void push_entry(int unsigned h, int unsigned span);
      if (stack_top < MAX_COLUMNS) begin
         stack_h[stack_top] = h[H_W-1:0];
         stack_w[stack_top] = span[SPAN_W-1:0];
         stack_top++;
      end
   endfunction

   function automatic void clear_grid();
      foreach (run_height[i]) run_height[i] = '0;
      best_area   = '0;
      stack_top   = 0;
      next_col    = 0;
      last_height = 0;
      row_open    = 1'b0;
   endfunction

   // one accepted cell: update heights and stack, owe an area on the end flag
   function automatic void take_cell(logic [CHAR_W-1:0] ch, bit first, bit last);
      int unsigned width;
      int unsigned col;
      int unsigned h;
      int unsigned popped;
      width = num_columns;
      if (width == 0) width = 1;
      if (width > MAX_COLUMNS) width = MAX_COLUMNS;
      if (first) clear_grid();

      col = next_col;
      if (col >= width) col = 0;

      // free run height, saturating
      h = run_height[col];
      if (ch == FREE_CHAR) begin
         h = (h < HEIGHT_LIMIT) ? h + 1 : HEIGHT_LIMIT;
      end else begin
         h = 0;
      end
      run_height[col] = h[H_W-1:0];

      // monotonic stack
      if (!row_open || h >= last_height) begin
         push_entry(h, 1);
      end else begin
         popped = pop_taller(int'(h));
         push_entry(h, popped + 1);
      end
      last_height = h;
      row_open    = 1'b1;

      // row flush on its last column or on the end flag
      if (col + 1 >= width || last) begin
         void'(pop_taller(-1));
         row_open    = 1'b0;
         next_col    = 0;
         last_height = 0;
      end else begin
         next_col = col + 1;
      end

      if (last) expected_areas.insert(expected_areas.size(), best_area);
   endfunction

   always @(posedge clock) begin : watch
      logic [AREA_W-1:0] want;
      if (reset) begin
         clear_grid();
         foreach (stack_h[i]) stack_h[i] = '0;
         foreach (stack_w[i]) stack_w[i] = '0;
         num_columns = MAX_COLUMNS[CFG_W-1:0];
         expected_areas.delete();
      end else begin
         // register write
         if (csr_valid && csr_ready) num_columns = csr_num_columns;

         // accepted request
         if (req_valid && !req_stall)
            take_cell(req_cell_char, req_start_of_matrix, req_end_of_matrix);

         // accepted result
         if (rsp_valid && !rsp_stall) begin
            if (expected_areas.size() == 0) begin
               report_mismatch($sformatf("max_area %0d with no area owed", rsp_max_area));
            end else begin
               want = expected_areas.pop_front();
               if (rsp_max_area !== want)
                  report_mismatch($sformatf("max_area got %0d expected %0d",
                                            rsp_max_area, want));
            end
         end
      end
      results_pending = expected_areas.size();
   end

endmodule

@@ tb/tb_max_rectangle_binary_grid.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_max_rectangle_binary_grid
// Streams character grids into the free rectangle finder: a directed set of
// rows, a height saturation column, a clamped column count, then random
// matrices over changing column counts with bursty requests and a stalling
// receiver.
// ----------------------------------------------------------------------------
module tb_max_rectangle_binary_grid;
   import mrbg_pkg::*;

   localparam int unsigned MAX_COLUMNS      = 1024;
   localparam int unsigned SETTLE_CYCLES    = 2500;
   localparam int unsigned CYCLE_LIMIT      = 1000000;
   localparam int unsigned LONG_HOLD_CYCLES = 1500;
   localparam int unsigned RANDOM_CELLS     = 200;
   localparam int unsigned RANDOM_RESULTS   = 20;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic [CHAR_W-1:0] req_cell_char = '0;
   logic              req_start_of_matrix = 1'b0;
   logic              req_end_of_matrix = 1'b0;
   logic              rsp_stall = 1'b0;
   logic              csr_valid = 1'b0;
   logic [CFG_W-1:0]  csr_num_columns = '0;
   wire logic              req_stall;
   wire logic              rsp_valid;
   wire logic [AREA_W-1:0] rsp_max_area;
   wire logic              csr_ready;
   int                mismatch_count;
   int                results_pending;

   // request bookkeeping
   int unsigned burst_left = 0;
   int unsigned cells_sent = 0;
   int unsigned ends_sent  = 0;
   bit          hold_request = 1'b0;

   max_rectangle_binary_grid dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_cell_char       (req_cell_char),
      .req_start_of_matrix (req_start_of_matrix),
      .req_end_of_matrix   (req_end_of_matrix),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_max_area        (rsp_max_area),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_num_columns     (csr_num_columns)
   );

   max_rectangle_binary_grid_checker area_monitor (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_cell_char       (req_cell_char),
      .req_start_of_matrix (req_start_of_matrix),
      .req_end_of_matrix   (req_end_of_matrix),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_max_area        (rsp_max_area),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_num_columns     (csr_num_columns),
      .mismatch_count      (mismatch_count),
      .results_pending     (results_pending)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // run limit
   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("FAIL max_rectangle_binary_grid");
      $finish;
   end

   // receiver: changing stall modes, one long hold once asked for
   initial begin : receiver
      int unsigned mode;
      int unsigned mode_left;
      int unsigned hold_left;
      bit          hold_done;
      mode_left = 0;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (hold_request && !hold_done) begin
            hold_left = LONG_HOLD_CYCLES;
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(0, 2);
               mode_left = $urandom_range(16, 200);
            end
            mode_left--;
            case (mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= 1'($urandom_range(0, 1));
               default: rsp_stall <= ($urandom_range(0, 9) < 8);
            endcase
         end
      end
   end

   function automatic logic [CHAR_W-1:0] pick_char(int unsigned free_pct);
      if ($urandom_range(0, 99) < free_pct) return FREE_CHAR;
      // near misses of the free character
      if ($urandom_range(0, 3) == 0) return FREE_CHAR ^ (8'h01 << $urandom_range(0, 7));
      return CHAR_W'($urandom_range(0, 255));
   endfunction

   function automatic int unsigned width_of(int unsigned v);
      if (v == 0) return 1;
      if (v > MAX_COLUMNS) return MAX_COLUMNS;
      return v;
   endfunction

   // one request, sent in bursts with random gaps
   task automatic send_cell(input logic [CHAR_W-1:0] ch, input bit first, input bit last);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_valid           <= 1'b1;
      req_cell_char       <= ch;
      req_start_of_matrix <= first;
      req_end_of_matrix   <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left--;
      cells_sent++;
      if (last) ends_sent++;
   endtask

   task automatic send_run(input int unsigned n, input int unsigned free_pct,
                           input bit first, input bit last);
      for (int unsigned i = 0; i < n; i++)
         send_cell(pick_char(free_pct), first && i == 0, last && i == n - 1);
   endtask

   task automatic write_columns(input int unsigned v);
      csr_valid       <= 1'b1;
      csr_num_columns <= v[CFG_W-1:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // all owed areas delivered, then room for a trailing row flush
   task automatic settle();
      req_valid <= 1'b0;
      do @(negedge clock); while (results_pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      int unsigned cfg;
      int unsigned width;
      int unsigned kind;
      int unsigned fill;
      int unsigned rows;
      int unsigned n;
      int unsigned base_cells;
      int unsigned base_ends;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows over four columns
      write_columns(4);
      send_cell(FREE_CHAR, 1, 0);
      send_cell(FREE_CHAR, 0, 0);
      send_cell(FREE_CHAR, 0, 0);
      send_cell(FREE_CHAR, 0, 0);
      send_cell(8'h00, 0, 0);
      send_cell(FREE_CHAR, 0, 0);
      send_cell(8'hFF, 0, 0);
      send_cell(FREE_CHAR, 0, 0);
      send_cell(FREE_CHAR, 0, 0);
      send_cell(FREE_CHAR, 0, 0);
      send_cell(FREE_CHAR, 0, 0);
      send_cell(8'h47, 0, 1);
      // restart mid-stream, end flag within a row
      send_cell(FREE_CHAR, 1, 0);
      send_cell(8'h45, 0, 0);
      send_cell(FREE_CHAR, 0, 1);
      // carry on without a start flag, heights kept
      send_cell(FREE_CHAR, 0, 0);
      send_cell(FREE_CHAR, 0, 0);
      send_cell(FREE_CHAR, 0, 0);
      send_cell(FREE_CHAR, 0, 0);
      send_cell(FREE_CHAR, 0, 1);
      // single cell matrices
      send_cell(FREE_CHAR, 1, 1);
      send_cell(8'h00, 1, 1);

      // zero columns acts as one: drive one column past its height limit
      settle();
      write_columns(0);
      send_cell(FREE_CHAR, 1, 0);
      send_run(1029, 100, 0, 0);
      send_cell(FREE_CHAR, 0, 1);
      send_cell(FREE_CHAR, 0, 1);

      settle();
      write_columns(1);
      send_run(6, 60, 1, 1);
      send_run(3, 50, 0, 1);

      // above the column limit: a short matrix on the clamped count
      settle();
      write_columns(2047);
      send_run(20, 90, 1, 1);

      settle();
      write_columns(MAX_COLUMNS);
      send_run(30, 70, 1, 1);

      // random matrices over changing column counts
      base_cells = cells_sent;
      base_ends  = ends_sent;
      while (cells_sent - base_cells < RANDOM_CELLS || ends_sent - base_ends < RANDOM_RESULTS) begin
         settle();
         kind = $urandom_range(0, 19);
         if (kind == 0)      cfg = 0;
         else if (kind == 1) cfg = $urandom_range(MAX_COLUMNS + 1, 2047);
         else if (kind == 2) cfg = MAX_COLUMNS;
         else                cfg = $urandom_range(1, 12);
         write_columns(cfg);
         width = width_of(cfg);
         hold_request = 1'b1;

         repeat ($urandom_range(4, 10)) begin
            kind = $urandom_range(0, 9);
            fill = $urandom_range(30, 95);
            rows = (width > 16) ? 1 : $urandom_range(1, 8);
            n    = (width > 16) ? $urandom_range(1, 40) : rows * width;
            if (kind <= 6) begin
               // well-formed matrix
               send_run(n, fill, 1, 1);
            end else if (kind == 7) begin
               // loose cells with stray flags
               repeat ($urandom_range(1, 15))
                  send_cell(pick_char(fill), $urandom_range(0, 7) == 0,
                            $urandom_range(0, 7) == 0);
            end else if (kind == 8) begin
               // no start flag, heights carried over
               send_run(n, fill, 0, 1);
            end else begin
               // matrix cut short by an early end flag
               send_run($urandom_range(1, n), fill, 1, 1);
            end
         end
         // close whatever row is open
         send_cell(pick_char(50), 0, 1);
      end

      settle();
      if (mismatch_count == 0 && results_pending == 0) begin
         $display("PASS max_rectangle_binary_grid");
      end else begin
         $display("FAIL max_rectangle_binary_grid");
      end
      $finish;
   end

endmodule
